/* hw/rtl/lcgrd_pkg.sv */
// shared types for the lcg64 random range draw block
package lcgrd_pkg;

    // seed register write as seen by the generator state
    typedef struct packed {
        logic        load;
        logic [63:0] value;
    } t_seed_load;

endpackage

/* hw/rtl/lcgrd_mul.sv */
// shared 32x32 multiplier with registered product
module lcgrd_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    // one product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= {32'h0, i_a} * {32'h0, i_b};
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/lcgrd_apb.sv */
// register port holding the start seed
module lcgrd_apb (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    output lcgrd_pkg::t_seed_load o_seed
);
    import lcgrd_pkg::*;

    localparam logic REG_SEED = 1'b0;

    logic [63:0] r_seed;
    logic        w_wr;

    // write strobe for the seed register
    assign w_wr = psel & penable & pwrite & (paddr[3] == REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
        end else if (w_wr) begin
            r_seed <= pwdata;
        end
    end

    // read back
    assign prdata       = (paddr[3] == REG_SEED) ? r_seed : 64'h0;
    assign pready       = 1'b1;
    assign o_seed.load  = w_wr;
    assign o_seed.value = pwdata;

endmodule

/* hw/rtl/lcg64_random_range_draw_top.sv */
// lcg64 random range draw: sequencer and datapath around one shared multiplier
//
// Usage: each word accepted on the s_axis side triggers one draw of a 64-bit
// linear congruential generator and returns one word on the m_axis side.
// s_axis_tuser carries the mode (0 fraction, 1 integer in range, 2 chance
// test); s_axis_tdata carries the range bounds and the chance ratio.
// m_axis_tdata returns the tempered 32-bit fraction, the range value, the
// hit flag and the new generator state.
// Sequence: the single 32x32 multiplier makes three passes for the 64-bit
// state product, the state updates in S_SUM, then S_OUT in mode 0 (and 3).
// Mode 2 adds one pass for the chance product and a compare; mode 1 adds one
// pass for the scaling product, then the division by 2^32-1 done as
// fold-and-correct steps on one adder chain. A zero interval or an inverted
// range finishes after the state update, as in mode 0.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; a new word is accepted while it
// waits, and a finished result holds until m_axis_tready frees the register.
// Reset clears the seed and the generator state to zero; writing the seed
// over the register port reloads the state. Write it only while idle.
module lcg64_random_range_draw_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s_axis_tdata: range_low[32:0], range_high[65:33],
    //               event_frequency[96:66], event_interval[127:97]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    // s_axis_tuser: func[1:0]
    input  logic [1:0]   s_axis_tuser,
    // m_axis_tdata: fraction_bits[31:0], range_value[64:32], chance_hit[65],
    //               state_now[129:66], zero pad[135:130]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import lcgrd_pkg::*;

    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [31:0] FRAC_MAX = 32'hFFFF_FFFF;
    localparam int          TEMPER_SHIFT = 22;

    localparam logic [1:0] FUNC_RANGE  = 2'd1;
    localparam logic [1:0] FUNC_CHANCE = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MLL  = 4'd1;
    localparam logic [3:0] S_MLH  = 4'd2;
    localparam logic [3:0] S_MHL  = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_MX   = 4'd5;
    localparam logic [3:0] S_DV0  = 4'd6;
    localparam logic [3:0] S_DV1  = 4'd7;
    localparam logic [3:0] S_DV2  = 4'd8;
    localparam logic [3:0] S_DV3  = 4'd9;
    localparam logic [3:0] S_DV4  = 4'd10;
    localparam logic [3:0] S_CMP  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    t_seed_load  w_seed;

    logic [3:0]   r_fsm;
    logic [3:0]   n_fsm;
    logic [1:0]   r_func;
    logic [32:0]  r_lo;
    logic [33:0]  r_span;
    logic         r_inv;
    logic [30:0]  r_freq;
    logic [30:0]  r_intv;
    logic [63:0]  r_state;
    logic [63:0]  n_state;
    logic [63:0]  r_acc;
    logic [65:0]  r_p;
    logic [33:0]  r_q;
    logic [34:0]  r_r;
    logic [32:0]  r_rv;
    logic         r_hit;
    logic         r_m_valid;
    logic [135:0] r_m_data;

    logic [31:0]  w_mul_a;
    logic [31:0]  w_mul_b;
    logic [63:0]  w_prod;
    logic [31:0]  w_x;
    logic [32:0]  w_lb;
    logic [32:0]  w_hb;
    logic [32:0]  w_extra;
    logic [33:0]  w_qinc;
    logic [33:0]  w_qcl;
    logic [63:0]  w_fd;
    logic         w_accept;
    logic         w_out_free;

    lcgrd_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (w_seed)
    );

    lcgrd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // tempered output of the current state
    assign w_x = r_state[31:0] ^ r_state[TEMPER_SHIFT +: 32];

    // offset binary bounds order like the signed values
    assign w_lb = {~s_axis_tdata[32], s_axis_tdata[31:0]};
    assign w_hb = {~s_axis_tdata[65], s_axis_tdata[64:33]};

    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = ~r_m_valid | m_axis_tready;

    // multiplier operand select per step
    always_comb begin
        case (r_fsm)
            S_MLL: begin
                w_mul_a = r_state[31:0];
                w_mul_b = LCG_MULT[31:0];
            end
            S_MLH: begin
                w_mul_a = r_state[31:0];
                w_mul_b = LCG_MULT[63:32];
            end
            S_MHL: begin
                w_mul_a = r_state[63:32];
                w_mul_b = LCG_MULT[31:0];
            end
            S_MX: begin
                w_mul_a = w_x;
                w_mul_b = (r_func == FUNC_RANGE) ? r_span[31:0] : {1'b0, r_intv};
            end
            default: begin
                w_mul_a = 32'h0;
                w_mul_b = 32'h0;
            end
        endcase
    end

    // low 64 bits of state times multiplier, plus the increment
    assign n_state = r_acc + {w_prod[31:0], 32'h0} + 64'd1;

    // upper span bits scale x by 0, 1 or 2 above bit 32
    assign w_extra = r_span[33] ? {w_x, 1'b0} : (r_span[32] ? {1'b0, w_x} : 33'h0);

    // final correction of the quotient and clamp to span minus one
    assign w_qinc = r_q + {33'h0, (r_r[32:0] >= {1'b0, FRAC_MAX})};
    assign w_qcl  = (w_qinc >= r_span) ? (r_span - 34'd1) : w_qinc;

    // frequency times 2^32-1
    assign w_fd = {1'b0, r_freq, 32'h0} - {33'h0, r_freq};

    // sequencer
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE: if (w_accept) n_fsm = S_MLL;
            S_MLL:  n_fsm = S_MLH;
            S_MLH:  n_fsm = S_MHL;
            S_MHL:  n_fsm = S_SUM;
            S_SUM: begin
                if (r_func == FUNC_RANGE && !r_inv) begin
                    n_fsm = S_MX;
                end else if (r_func == FUNC_CHANCE && r_intv != 31'h0) begin
                    n_fsm = S_MX;
                end else begin
                    n_fsm = S_OUT;
                end
            end
            S_MX:   n_fsm = (r_func == FUNC_RANGE) ? S_DV0 : S_CMP;
            S_DV0:  n_fsm = S_DV1;
            S_DV1:  n_fsm = S_DV2;
            S_DV2:  n_fsm = S_DV3;
            S_DV3:  n_fsm = S_DV4;
            S_DV4:  n_fsm = S_OUT;
            S_CMP:  n_fsm = S_OUT;
            S_OUT:  if (w_out_free) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_m_valid <= 1'b0;
            r_state   <= 64'h0;
        end else begin
            r_fsm <= n_fsm;
            if (r_fsm == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_seed.load) begin
                r_state <= w_seed.value;
            end else if (r_fsm == S_SUM) begin
                r_state <= n_state;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    r_func <= s_axis_tuser;
                    r_lo   <= s_axis_tdata[32:0];
                    r_inv  <= (w_hb < w_lb);
                    r_span <= {1'b0, w_hb} - {1'b0, w_lb} + 34'd1;
                    r_freq <= s_axis_tdata[96:66];
                    r_intv <= s_axis_tdata[127:97];
                    r_rv   <= 33'h0;
                    r_hit  <= 1'b0;
                end
            end
            S_MLH: r_acc <= w_prod;
            S_MHL: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            S_SUM: begin
                if (r_func == FUNC_RANGE && r_inv) begin
                    r_rv <= r_lo;
                end
                if (r_func == FUNC_CHANCE && r_intv == 31'h0) begin
                    r_hit <= (r_freq != 31'h0);
                end
            end
            // full scaled product x * span
            S_DV0: r_p <= {2'b00, w_prod} + {w_extra, 32'h0};
            // fold: P = q1*(2^32-1) + (low + q1)
            S_DV1: begin
                r_q <= r_p[65:32];
                r_r <= {3'b000, r_p[31:0]} + {1'b0, r_p[65:32]};
            end
            // second fold of the remainder
            S_DV2: begin
                r_q <= r_q + {31'h0, r_r[34:32]};
                r_r <= {2'b00, {1'b0, r_r[31:0]} + {30'h0, r_r[34:32]}};
            end
            S_DV3: r_q <= w_qcl;
            S_DV4: r_rv <= r_lo + r_q[32:0];
            S_CMP: r_hit <= (w_prod < w_fd);
            S_OUT: begin
                if (w_out_free) begin
                    r_m_data <= {6'h0, r_state, r_hit, r_rv, w_x};
                end
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_fsm == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

/* hw/rtl/lcgrd_checker.sv */
// port-level checks for the lcg64 random range draw block, bound to the top
module lcgrd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // one draw at a time: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a draw is in progress");

    // a chance hit never comes with a range value
    a_hit_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[64:32] == 33'h0)
        else $error("chance hit together with nonzero range value");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lcg64_random_range_draw_top lcgrd_checker u_lcgrd_checker (.*);

/* test/testbench.sv */
// testbench for the lcg64 random range draw block: predicts every draw and checks each result word
`timescale 1ns / 1ps

localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
localparam logic [32:0] SIGN_BIT  = 33'h1_0000_0000;
localparam logic [32:0] LO_MIN    = 33'h1_8000_0000;   // -2^31
localparam logic [32:0] HI_MAX    = 33'h0_FFFF_FFFF;   // 2^32-1
localparam logic [32:0] ABS_MIN   = 33'h1_0000_0000;   // -2^32
localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;
localparam logic [65:0] FRAC_DIV  = 66'h0_FFFF_FFFF;
localparam logic [3:0]  SEED_ADDR  = 4'd0;
localparam logic [3:0]  SPARE_ADDR = 4'd8;

typedef enum logic [1:0] {
    FN_FRACTION = 2'd0,
    FN_RANGE    = 2'd1,
    FN_CHANCE   = 2'd2,
    FN_SPARE    = 2'd3
} draw_func_e;

// input word, packed so that bits [127:0] are the tdata layout
typedef struct packed {
    draw_func_e  func;
    logic [30:0] event_interval;
    logic [30:0] event_frequency;
    logic [32:0] range_high;
    logic [32:0] range_low;
} draw_item;

// result word, packed in the m_axis_tdata layout without the pad
typedef struct packed {
    logic [63:0] state_now;
    logic        chance_hit;
    logic [32:0] range_value;
    logic [31:0] fraction_bits;
} draw_result;

class draw_scoreboard;
    logic [63:0] gen_state;
    draw_result  expected_draws[$];
    int          mismatches;

    function new();
        gen_state  = '0;
        mismatches = 0;
    endfunction

    function void load_seed(logic [63:0] value);
        gen_state = value;
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction

    // advance the generator and work out the result of one draw
    function void note_draw(draw_item it);
        logic [32:0] lb, hb;
        logic [33:0] span, q;
        logic [65:0] prod;
        draw_result  r;
        gen_state = gen_state * LCG_MULT + 64'd1;
        r = '0;
        r.state_now     = gen_state;
        r.fraction_bits = gen_state[31:0] ^ gen_state[53:22];
        case (it.func)
            FN_RANGE: begin
                // offset binary orders like signed
                lb = it.range_low ^ SIGN_BIT;
                hb = it.range_high ^ SIGN_BIT;
                if (hb < lb) begin
                    r.range_value = it.range_low;
                end else begin
                    span = {1'b0, hb} - {1'b0, lb} + 34'd1;
                    prod = {34'd0, r.fraction_bits} * {32'd0, span};
                    q    = 34'(prod / FRAC_DIV);
                    // full-scale fraction would land one past the top
                    if (q >= span) begin
                        q = span - 34'd1;
                    end
                    r.range_value = it.range_low + q[32:0];
                end
            end
            FN_CHANCE: begin
                if (it.event_interval == '0) begin
                    r.chance_hit = (it.event_frequency != '0);
                end else begin
                    r.chance_hit = ({32'd0, r.fraction_bits} * {33'd0, it.event_interval})
                                 < ({33'd0, it.event_frequency} * 64'h0000_0000_FFFF_FFFF);
                end
            end
            default: begin
            end
        endcase
        expected_draws.push_back(r);
    endfunction

    // compare one result word with the oldest expected draw
    function void check_result(logic [135:0] word);
        draw_result got, want;
        got = draw_result'(word[129:0]);
        if (expected_draws.size() == 0) begin
            $error("result word with no draw pending: %h", word);
            mismatches++;
            return;
        end
        want = expected_draws.pop_front();
        if (word[135:130] != '0) begin
            $error("zero_pad: expected %h, actual %h", 6'd0, word[135:130]);
            mismatches++;
        end
        if (got.fraction_bits != want.fraction_bits) begin
            $error("fraction_bits: expected %h, actual %h", want.fraction_bits,
                   got.fraction_bits);
            mismatches++;
        end
        if (got.range_value != want.range_value) begin
            $error("range_value: expected %h, actual %h", want.range_value, got.range_value);
            mismatches++;
        end
        if (got.chance_hit != want.chance_hit) begin
            $error("chance_hit: expected %b, actual %b", want.chance_hit, got.chance_hit);
            mismatches++;
        end
        if (got.state_now != want.state_now) begin
            $error("state_now: expected %h, actual %h", want.state_now, got.state_now);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    draw_scoreboard board;
    logic           calm = 1'b0;
    int             hold_left = 0;

    lcg64_random_range_draw_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // result side: check accepted words, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
        end
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= $urandom_range(0, 7);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic draw_item make_draw(draw_func_e f, logic [32:0] lo, logic [32:0] hi,
                                           logic [30:0] fr, logic [30:0] iv);
        draw_item it;
        it.func            = f;
        it.range_low       = lo;
        it.range_high      = hi;
        it.event_frequency = fr;
        it.event_interval  = iv;
        return it;
    endfunction

    // seed whose next state tempers to an all-ones fraction
    function automatic logic [63:0] fullscale_seed(logic [31:0] upper);
        logic [63:0] t, inv;
        t = {upper, 32'd0};
        for (int i = 31; i >= 0; i--) begin
            t[i] = ~t[i + 22];
        end
        inv = LCG_MULT;
        repeat (6) inv = inv * (64'd2 - LCG_MULT * inv);
        return (t - 64'd1) * inv;
    endfunction

    function automatic logic [32:0] rand_bound();
        logic [32:0] mag;
        case ($urandom_range(0, 3))
            0: return {1'b0, 32'($urandom)};
            1: begin
                mag = {1'b0, 32'($urandom_range(1, 32'h8000_0000))};
                return -mag;
            end
            2: return 33'($urandom_range(0, 32)) - 33'd16;
            default: begin
                case ($urandom_range(0, 2))
                    0: return LO_MIN;
                    1: return HI_MAX;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic draw_item rand_draw();
        draw_item    it;
        logic [32:0] a, b;
        logic [33:0] h;
        int          pick;
        pick = $urandom_range(0, 15);
        if (pick < 4) begin
            it.func = FN_FRACTION;
        end else if (pick < 10) begin
            it.func = FN_RANGE;
        end else if (pick < 15) begin
            it.func = FN_CHANCE;
        end else begin
            it.func = FN_SPARE;
        end
        a = rand_bound();
        b = rand_bound();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // narrow range, kept below the top bound
                h = {a[32], a} + 34'($urandom_range(0, 64));
                it.range_low  = a;
                it.range_high = (h[33] != h[32]) ? a : h[32:0];
            end
            5, 6: begin
                it.range_low  = ($signed(a) <= $signed(b)) ? a : b;
                it.range_high = ($signed(a) <= $signed(b)) ? b : a;
            end
            7: begin
                it.range_low  = ($signed(a) <= $signed(b)) ? b : a;
                it.range_high = ($signed(a) <= $signed(b)) ? a : b;
            end
            8: begin
                a = {1'($urandom), 32'($urandom)};
                b = {1'($urandom), 32'($urandom)};
                it.range_low  = ($signed(a) <= $signed(b)) ? a : b;
                it.range_high = ($signed(a) <= $signed(b)) ? b : a;
            end
            default: begin
                it.range_low  = {1'($urandom), 32'($urandom)};
                it.range_high = {1'($urandom), 32'($urandom)};
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                it.event_interval  = 31'($urandom_range(1, 32'h7FFF_FFFF));
                it.event_frequency = 31'($urandom_range(0, 32'(it.event_interval)));
            end
            6: begin
                it.event_interval  = 31'($urandom_range(1, 16));
                it.event_frequency = 31'($urandom_range(0, 20));
            end
            7: begin
                it.event_interval  = '0;
                it.event_frequency = ($urandom_range(0, 1) == 0) ? '0 : 31'($urandom);
            end
            default: begin
                it.event_interval  = 31'($urandom);
                it.event_frequency = 31'($urandom);
            end
        endcase
        return it;
    endfunction

    // present one word, with an occasional gap ahead of it
    task automatic send_draw(input draw_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it[127:0];
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_draw(it);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        drain();
        repeat (12) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == SEED_ADDR) begin
            board.load_seed(value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                drain();
            end
            send_draw(rand_draw());
        end
    endtask

    // main sequence
    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed draws from the reset state
        send_draw(make_draw(FN_FRACTION, '0, '0, '0, '0));
        send_draw(make_draw(FN_FRACTION, '1, '1, '1, '1));
        send_draw(make_draw(FN_RANGE, LO_MIN, HI_MAX, '0, '0));
        send_draw(make_draw(FN_RANGE, LO_MIN, LO_MIN, '0, '0));
        send_draw(make_draw(FN_RANGE, HI_MAX, HI_MAX, '0, '0));
        send_draw(make_draw(FN_RANGE, '0, '0, '0, '0));
        send_draw(make_draw(FN_RANGE, HI_MAX, LO_MIN, '0, '0));
        send_draw(make_draw(FN_RANGE, ABS_MIN, HI_MAX, '0, '0));
        send_draw(make_draw(FN_RANGE, '1, 33'd1, '0, '0));
        send_draw(make_draw(FN_CHANCE, '0, '0, '0, '0));
        send_draw(make_draw(FN_CHANCE, '0, '0, 31'd1, '0));
        send_draw(make_draw(FN_CHANCE, '0, '0, RATIO_MAX, '0));
        send_draw(make_draw(FN_CHANCE, '0, '0, RATIO_MAX, RATIO_MAX));
        send_draw(make_draw(FN_CHANCE, '0, '0, RATIO_MAX, 31'd1));
        send_draw(make_draw(FN_CHANCE, '0, '0, '0, RATIO_MAX));
        send_draw(make_draw(FN_CHANCE, '0, '0, 31'd1, RATIO_MAX));
        send_draw(make_draw(FN_SPARE, LO_MIN, HI_MAX, RATIO_MAX, RATIO_MAX));

        // full-scale fraction in each mode that reads it
        write_reg(SEED_ADDR, fullscale_seed($urandom));
        send_draw(make_draw(FN_RANGE, LO_MIN, HI_MAX, '0, '0));
        write_reg(SEED_ADDR, fullscale_seed($urandom));
        send_draw(make_draw(FN_RANGE, 33'd7, 33'd107, '0, '0));
        write_reg(SEED_ADDR, fullscale_seed($urandom));
        send_draw(make_draw(FN_CHANCE, '0, '0, 31'd12345, 31'd12345));

        // random phases over several seeds, a write to an unused index between
        write_reg(SEED_ADDR, '1);
        write_reg(SPARE_ADDR, {$urandom, $urandom});
        run_random(300, -1);
        write_reg(SEED_ADDR, '0);
        run_random(300, 150);
        write_reg(SEED_ADDR, {$urandom, $urandom});
        write_reg(SPARE_ADDR, '1);
        run_random(300, 40);
        write_reg(SEED_ADDR, {$urandom, $urandom});
        calm <= 1'b1;
        run_random(400, -1);

        drain();
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lcgrd_pkg.sv
hw/rtl/lcgrd_mul.sv
hw/rtl/lcgrd_apb.sv
hw/rtl/lcg64_random_range_draw_top.sv
hw/rtl/lcgrd_checker.sv
test/testbench.sv
